/* rtl/core/tcv_pkg.sv */
package tcv_pkg;

	localparam int MODE_W     = 1;
	localparam int CLASS_IDX_W = 4;
	localparam int CLAUSE_IDX_W = 5;
	localparam int MASK_W     = 64;
	localparam int FEAT_W     = 32;
	localparam int VOTE_W     = 6;
	localparam int CLASS_CNT_W = 5;
	localparam int CLAUSE_CNT_W = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLAUSE_COUNT = 1'd1;

	localparam logic MODE_WRITE    = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} tcv_state_t;

endpackage

/* rtl/core/tcv_ram.sv */
module tcv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/tcv_front.sv */
// accepts input transactions and pushes them into the command queue
module tcv_front #(
	parameter int DEPTH_LOG = 2,
	parameter int PAY_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PAY_W-1:0] in_pay,
	output logic             q_valid,
	input  logic             q_ready,
	output logic [PAY_W-1:0] q_pay
);

	localparam int DEPTH = 1 << DEPTH_LOG;

	logic [PAY_W-1:0]   buf_q [DEPTH];
	logic [DEPTH_LOG:0] wp_q, rp_q;
	logic [DEPTH_LOG:0] fill;

	assign fill     = wp_q - rp_q;
	assign in_ready = (fill != (DEPTH_LOG+1)'(DEPTH));
	assign q_valid  = (fill != '0);
	assign q_pay    = buf_q[rp_q[DEPTH_LOG-1:0]];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wp_q[DEPTH_LOG-1:0]] <= in_pay;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (in_valid && in_ready) wp_q <= wp_q + 1'b1;
			if (q_valid && q_ready) rp_q <= rp_q + 1'b1;
		end
	end

endmodule

/* rtl/core/tcv_back.sv */
// executes queued commands: mask writes and clause sweeps
module tcv_back #(
	parameter int NUM_FEATURES = 32,
	parameter int MAX_CLASSES  = 16,
	parameter int MAX_CLAUSES  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  logic                              q_mode,
	input  logic [tcv_pkg::CLASS_IDX_W-1:0]   q_class,
	input  logic [tcv_pkg::CLAUSE_IDX_W-1:0]  q_clause,
	input  logic [tcv_pkg::MASK_W-1:0]        q_mask,
	input  logic [tcv_pkg::FEAT_W-1:0]        q_feat,
	input  logic [tcv_pkg::CLASS_CNT_W-1:0]   class_count,
	input  logic [tcv_pkg::CLAUSE_CNT_W-1:0]  clause_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tcv_pkg::CLASS_IDX_W-1:0]   result_class,
	output logic signed [tcv_pkg::VOTE_W-1:0] vote_sum,
	output logic                              decision,
	output logic [tcv_pkg::CLASS_IDX_W-1:0]   winner,
	output logic                              last
);
	import tcv_pkg::*;

	localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int CL_W   = $clog2(MAX_CLAUSES);
	localparam int ADDR_W = CLS_W + CL_W;
	localparam int DEPTH  = MAX_CLASSES * MAX_CLAUSES;
	localparam int ACC_W  = CL_W + 2;

	tcv_state_t state_q, state_d;

	logic [CLS_W-1:0]   cls_q;
	logic [CL_W-1:0]    cl_q;
	logic [CLS_W-1:0]   ncls_m1_q;
	logic [CL_W:0]      ncl_q;
	logic [2*NUM_FEATURES-1:0] lits_q;
	logic [NUM_FEATURES-1:0]   pos;

	logic               rd_s1, rd_par_s1;
	logic [MASK_W-1:0]  rdata;
	logic signed [ACC_W-1:0] acc_q, best_q, vote_fin_q;
	logic signed [ACC_W-1:0] acc_nx;
	logic [CLS_W-1:0]   win_q;

	logic               we, re, rd_end;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic               hit;
	logic [CLASS_CNT_W-1:0] ncls_c;
	logic [CLAUSE_CNT_W-1:0] ncl_c;
	logic               zero_cl;

	assign pos = q_feat[NUM_FEATURES-1:0];

	always_comb begin
		ncls_c = class_count;
		if (ncls_c == '0) ncls_c = CLASS_CNT_W'(1);
		if (32'(ncls_c) > MAX_CLASSES) ncls_c = CLASS_CNT_W'(MAX_CLASSES);
		ncl_c = clause_count;
		if (32'(ncl_c) > MAX_CLAUSES) ncl_c = CLAUSE_CNT_W'(MAX_CLAUSES);
	end

	assign zero_cl = (ncl_q == '0);
	assign we    = (state_q == ST_IDLE) && q_valid && (q_mode == MODE_WRITE)
		&& (32'(q_class) < MAX_CLASSES) && (32'(q_clause) < MAX_CLAUSES);
	assign waddr = {q_class[CLS_W-1:0], q_clause[CL_W-1:0]};
	assign re    = (state_q == ST_RUN) && !zero_cl;
	assign raddr = {cls_q, cl_q};
	assign rd_end = zero_cl || ((CL_W+1)'(cl_q) == ncl_q - 1'b1);

	tcv_ram #(.WIDTH(MASK_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (q_mask),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign hit = ((rdata[2*NUM_FEATURES-1:0] & ~lits_q) == '0);

	// even clauses vote up, odd clauses vote down
	assign acc_nx = (rd_s1 && hit)
		? (rd_par_s1 ? acc_q - ACC_W'(1) : acc_q + ACC_W'(1)) : acc_q;

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_ready = 1'b1;
					if (q_mode == MODE_CLASSIFY) state_d = ST_RUN;
				end
			end
			ST_RUN:   if (rd_end) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready) begin
					if (cls_q == ncls_m1_q) state_d = ST_IDLE;
					else state_d = ST_RUN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= re;
		end
	end

	// sweep counters and vote accumulation
	always_ff @(posedge clk) begin
		rd_par_s1 <= cl_q[0];
		unique case (state_q)
			ST_IDLE: begin
				cls_q     <= '0;
				cl_q      <= '0;
				acc_q     <= '0;
				best_q    <= '0;
				win_q     <= '0;
				ncls_m1_q <= CLS_W'(ncls_c - 1'b1);
				ncl_q     <= (CL_W+1)'(ncl_c);
				lits_q    <= {~pos, pos};
			end
			ST_RUN: begin
				if (!rd_end) cl_q <= cl_q + 1'b1;
				acc_q <= acc_nx;
			end
			// last read lands during drain, fold it in before finishing
			ST_DRAIN: begin
				vote_fin_q <= acc_nx;
				if (acc_nx > best_q) begin
					best_q <= acc_nx;
					win_q  <= cls_q;
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					cls_q <= cls_q + 1'b1;
					cl_q  <= '0;
					acc_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = (state_q == ST_EMIT);
	assign result_class = CLASS_IDX_W'(cls_q);
	assign last         = (cls_q == ncls_m1_q);
	assign winner       = last ? CLASS_IDX_W'(win_q) : '0;
	assign decision     = (vote_fin_q > 0);
	always_comb begin
		if (vote_fin_q > ACC_W'(31)) vote_sum = VOTE_W'(31);
		else if (vote_fin_q < -ACC_W'(32)) vote_sum = -VOTE_W'(32);
		else vote_sum = VOTE_W'(vote_fin_q);
	end

endmodule

/* rtl/core/tsetlin_clause_vote_classifier_top.sv */
// channel | signals                                        | role
// in      | in_valid/in_ready, mode..features              | mask write or classify
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data       | class/clause counts
// out     | out_valid/out_ready, result_class..last        | one vote per class
// a mask write is taken by the back end while it is idle; a classify item reads
// each class's clauses in turn through the single read port of the mask memory,
// and the back end takes no new item until the last class's vote has been accepted
// a four-entry queue lets inputs be taken while the back end works or stalls
// reset clears control only; mask memory is undefined until written
module tsetlin_clause_vote_classifier_top #(
	parameter int NUM_FEATURES = 32,
	parameter int MAX_CLASSES  = 16,
	parameter int MAX_CLAUSES  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [tcv_pkg::CLASS_IDX_W-1:0]   class_index,
	input  logic [tcv_pkg::CLAUSE_IDX_W-1:0]  clause_index,
	input  logic [tcv_pkg::MASK_W-1:0]        include_mask,
	input  logic [tcv_pkg::FEAT_W-1:0]        features,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcv_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tcv_pkg::CLASS_IDX_W-1:0]   result_class,
	output logic signed [tcv_pkg::VOTE_W-1:0] vote_sum,
	output logic                              decision,
	output logic [tcv_pkg::CLASS_IDX_W-1:0]   winner,
	output logic                              last
);
	import tcv_pkg::*;

	localparam int PAY_W = MODE_W + CLASS_IDX_W + CLAUSE_IDX_W + MASK_W + FEAT_W;

	logic [CLASS_CNT_W-1:0]  class_count_q;
	logic [CLAUSE_CNT_W-1:0] clause_count_q;
	logic             q_valid, q_ready;
	logic [PAY_W-1:0] q_pay;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q  <= CLASS_CNT_W'(10);
			clause_count_q <= CLAUSE_CNT_W'(32);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CLASS_COUNT:  class_count_q  <= cfg_data[CLASS_CNT_W-1:0];
				CFG_CLAUSE_COUNT: clause_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tcv_front #(.DEPTH_LOG(2), .PAY_W(PAY_W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_pay   ({mode, class_index, clause_index, include_mask, features}),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_pay    (q_pay)
	);

	tcv_back #(
		.NUM_FEATURES (NUM_FEATURES),
		.MAX_CLASSES  (MAX_CLASSES),
		.MAX_CLAUSES  (MAX_CLAUSES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_mode       (q_pay[PAY_W-1]),
		.q_class      (q_pay[PAY_W-2 -: CLASS_IDX_W]),
		.q_clause     (q_pay[PAY_W-2-CLASS_IDX_W -: CLAUSE_IDX_W]),
		.q_mask       (q_pay[FEAT_W +: MASK_W]),
		.q_feat       (q_pay[FEAT_W-1:0]),
		.class_count  (class_count_q),
		.clause_count (clause_count_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_class (result_class),
		.vote_sum     (vote_sum),
		.decision     (decision),
		.winner       (winner),
		.last         (last)
	);

endmodule

/* dv/testbench.sv */
module testbench;
	import tcv_pkg::*;

	localparam int N_CLS       = 16;
	localparam int N_CL        = 32;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 600;
	// every class has clauses below LOW_CL loaded, class 0 has all of them
	localparam int LOW_CL      = 8;

	typedef struct {
		logic [CLASS_IDX_W-1:0] cls;
		logic signed [VOTE_W-1:0] vote;
		logic decision;
		logic [CLASS_IDX_W-1:0] win;
		logic fin;
	} vote_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = MODE_WRITE;
	logic [CLASS_IDX_W-1:0] class_index = '0;
	logic [CLAUSE_IDX_W-1:0] clause_index = '0;
	logic [MASK_W-1:0] include_mask = '0;
	logic [FEAT_W-1:0] features = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_CLASS_COUNT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CLASS_IDX_W-1:0] result_class;
	logic signed [VOTE_W-1:0] vote_sum;
	logic decision;
	logic [CLASS_IDX_W-1:0] winner;
	logic last;

	// predictor state
	logic [MASK_W-1:0] mask_store [N_CLS][N_CL];
	logic [CLASS_CNT_W-1:0] cls_cnt;
	logic [CLAUSE_CNT_W-1:0] cl_cnt;
	vote_rec_t vote_q [$];

	int send_idle = 0;
	int recv_idle = 0;
	int errors = 0;
	int n_writes = 0;
	int n_classify = 0;
	int n_votes = 0;
	int n_cfg = 0;
	int unsigned cycles = 0;

	tsetlin_clause_vote_classifier_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .class_index(class_index), .clause_index(clause_index),
		.include_mask(include_mask), .features(features),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_class(result_class), .vote_sum(vote_sum), .decision(decision),
		.winner(winner), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("tsetlin_clause_vote_classifier_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	function automatic void predict_votes(input logic [FEAT_W-1:0] feat);
		logic [MASK_W-1:0] lits;
		int ncls, ncl, v, best, win;
		vote_rec_t r;
		lits = {~feat, feat};
		ncls = cls_cnt;
		if (ncls < 1) ncls = 1;
		if (ncls > N_CLS) ncls = N_CLS;
		ncl = cl_cnt;
		if (ncl > N_CL) ncl = N_CL;
		best = 0;
		win = 0;
		for (int c = 0; c < ncls; c++) begin
			v = 0;
			for (int k = 0; k < ncl; k++)
				if ((mask_store[c][k] & ~lits) == '0) v += (k % 2 == 0) ? 1 : -1;
			if (v > best) begin
				best = v;
				win = c;
			end
			r.cls = CLASS_IDX_W'(c);
			r.vote = VOTE_W'((v > 31) ? 31 : (v < -32) ? -32 : v);
			r.decision = (v > 0);
			r.win = CLASS_IDX_W'((c == ncls - 1) ? win : 0);
			r.fin = (c == ncls - 1);
			vote_q.push_back(r);
		end
	endfunction

	// compare each vote transaction with the oldest expected one
	always @(posedge clk) begin
		vote_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			n_votes++;
			if (vote_q.size() == 0) begin
				errors++;
				$display("%0t: expected no vote, got class %0d vote %0d", $time,
					result_class, vote_sum);
			end else begin
				e = vote_q.pop_front();
				if (e.cls !== result_class || e.vote !== vote_sum ||
					e.decision !== decision || e.win !== winner || e.fin !== last) begin
					errors++;
					$display("%0t: mismatch exp cls %0d vote %0d dec %0d win %0d last %0d",
						$time, e.cls, e.vote, e.decision, e.win, e.fin);
					$display("%0t:          got cls %0d vote %0d dec %0d win %0d last %0d",
						$time, result_class, vote_sum, decision, winner, last);
				end
			end
		end
	end

	task automatic send_item(input logic m, input logic [CLASS_IDX_W-1:0] ci,
		input logic [CLAUSE_IDX_W-1:0] li, input logic [MASK_W-1:0] msk,
		input logic [FEAT_W-1:0] feat);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		class_index <= ci;
		clause_index <= li;
		include_mask <= msk;
		features <= feat;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (m == MODE_WRITE) begin
			mask_store[ci][li] = msk;
			n_writes++;
		end else begin
			predict_votes(feat);
			n_classify++;
		end
	endtask

	// lower valid in the step of the last transaction and let the block go quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (vote_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_CLASS_COUNT) cls_cnt = d[CLASS_CNT_W-1:0];
		else cl_cnt = d;
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic set_counts(input int cc, input int kc);
		drain();
		cfg_write(CFG_CLASS_COUNT, CFG_DATA_W'(cc));
		cfg_write(CFG_CLAUSE_COUNT, CFG_DATA_W'(kc));
	endtask

	// mostly one to three literals so that clauses fire now and then
	function automatic logic [MASK_W-1:0] rand_mask();
		logic [MASK_W-1:0] m;
		int r, n;
		r = $urandom_range(99);
		m = '0;
		if (r < 10) return '0;
		if (r < 18) return {$urandom, $urandom};
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			m[$urandom_range(31) + ($urandom_range(1) ? 32 : 0)] = 1'b1;
		return m;
	endfunction

	function automatic logic [FEAT_W-1:0] rand_features();
		int r;
		r = $urandom_range(99);
		if (r < 5) return '0;
		if (r < 10) return '1;
		return $urandom;
	endfunction

	// low clauses of every class, and every clause of class 0
	task automatic load_masks();
		for (int c = 0; c < N_CLS; c++)
			for (int k = 0; k < LOW_CL; k++)
				send_item(MODE_WRITE, CLASS_IDX_W'(c), CLAUSE_IDX_W'(k), rand_mask(), $urandom);
		for (int k = LOW_CL; k < N_CL; k++)
			send_item(MODE_WRITE, '0, CLAUSE_IDX_W'(k), rand_mask(), $urandom);
	endtask

	task automatic test_extremes();
		// all classes over the loaded clauses
		set_counts(16, LOW_CL);
		send_item(MODE_WRITE, 4'd0, 5'd0, '1, '0);
		send_item(MODE_WRITE, 4'd15, 5'd7, '0, '1);
		send_item(MODE_WRITE, 4'd3, 5'd2, 64'h1, '0);
		send_item(MODE_WRITE, 4'd3, 5'd4, 64'h1_0000_0000, '0);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, '0);
		send_item(MODE_CLASSIFY, 4'd15, 5'd31, '1, '1);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, 32'h1);
		// one class over every clause
		set_counts(1, 32);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, $urandom);
		set_counts(1, 1);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, $urandom);
		// zero classes used as one, zero clauses give zero votes
		set_counts(0, 0);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, $urandom);
		// counts above the maximum are clamped
		set_counts(31, LOW_CL);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, '1);
		set_counts(1, 63);
		send_item(MODE_CLASSIFY, 4'd0, 5'd0, '0, '0);
	endtask

	task automatic test_random(input int n_items);
		int cc, kc, r;
		for (int i = 0; i < n_items; i++) begin
			if (i % 20 == 0) begin
				r = $urandom_range(99);
				if (r < 10) begin
					cc = $urandom_range(1) ? 31 : 16;
					kc = LOW_CL;
				end else if (r < 15) begin
					cc = 0;
					kc = $urandom_range(1) ? 0 : 1;
				end else if (r < 25) begin
					cc = $urandom_range(1);
					kc = $urandom_range(1) ? 63 : 32;
				end else begin
					cc = $urandom_range(1, 5);
					kc = $urandom_range(1, LOW_CL);
				end
				set_counts(cc, kc);
			end
			if ($urandom_range(99) < 55)
				send_item(MODE_WRITE, CLASS_IDX_W'($urandom_range(15)),
					CLAUSE_IDX_W'($urandom_range(31)), rand_mask(), $urandom);
			else
				send_item(MODE_CLASSIFY, CLASS_IDX_W'($urandom_range(15)),
					CLAUSE_IDX_W'($urandom_range(31)), {$urandom, $urandom},
					rand_features());
		end
	endtask

	initial begin
		cls_cnt = 10;
		cl_cnt = 32;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle = 8;
		recv_idle = 53;
		load_masks();
		test_extremes();
		test_random(27);
		send_idle = 53;
		recv_idle = 8;
		test_random(27);
		send_idle = 0;
		recv_idle = 0;
		test_random(27);
		drain();
		repeat (SETTLE) @(posedge clk);
		if (vote_q.size() != 0) begin
			errors++;
			$display("%0t: %0d expected votes never arrived", $time, vote_q.size());
		end
		$display("covered %0d mask writes, %0d classify items, %0d votes, %0d count writes",
			n_writes, n_classify, n_votes, n_cfg);
		$display("three stall mixes, counts from zero to beyond the maximum; %0d errors",
			errors);
		if (errors == 0)
			$display("tsetlin_clause_vote_classifier_top regression: pass");
		else
			$display("tsetlin_clause_vote_classifier_top regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/tcv_pkg.sv
rtl/core/tcv_ram.sv
rtl/core/tcv_front.sv
rtl/core/tcv_back.sv
rtl/core/tsetlin_clause_vote_classifier_top.sv
dv/testbench.sv
